>>> hdl/cfa_pkg.sv
// shared types, constants and codes for the contiguous fit allocator
`timescale 1ns / 1ps
package cfa_pkg;
	localparam int HOLE_SLOTS_DEF = 16;
	localparam int SEG_SLOTS_DEF = 16;
	localparam int ADDR_BITS = 16;
	localparam int ID_BITS = 8;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_ALLOC = 2'd1,
		FUNC_FREE = 2'd2,
		FUNC_MERGE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_NO_ID = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST = 2'd1,
		FIT_WORST = 2'd2,
		FIT_OTHER = 2'd3
	} fit_t;

	typedef struct packed {
		logic [1:0] func;
		logic [ID_BITS-1:0] proc_id;
		logic [ADDR_BITS-1:0] req_size;
		logic [ADDR_BITS-1:0] region_start;
		logic [ADDR_BITS-1:0] region_end;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ADDR_BITS-1:0] seg_start;
		logic [ADDR_BITS-1:0] seg_end;
	} rsp_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_HSCAN,
		S_SSCAN,
		S_HINS,
		S_HDROP,
		S_SINS,
		S_SDROP,
		S_MERGE,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr_idx;
		logic step_idx;
		logic dec_idx;
		logic hscan;
		logic sscan;
		logic hins_shift;
		logic hins_put;
		logic hdrop_shift;
		logic hdrop_fin;
		logic hstart_upd;
		logic sins_shift;
		logic sins_put;
		logic sdrop_shift;
		logic sdrop_fin;
		logic merge_step;
		logic merge_fin;
		logic set_idx_cnt_h;
		logic set_idx_cnt_s;
		logic set_idx_pick;
		logic set_idx_at;
		logic done;
		logic [1:0] st;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] func;
		logic hfull;
		logic sfull;
		logic region_ok;
		logic idx_at_h;
		logic idx_at_s;
		logic seg_nonempty;
		logic hshift_cond;
		logic sshift_cond;
		logic hfound;
		logic first_mode;
		logic sfound;
		logic exact;
		logic free_nonempty;
		logic hcnt_gt1;
		logic drop_last_h;
		logic drop_last_s;
	} sts_t;
endpackage

>>> hdl/cfa_ctrl.sv
// controller state machine sequencing scans and table shifts
`timescale 1ns / 1ps
module cfa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cfa_pkg::sts_t sts,
	output cfa_pkg::cmd_t cmd
);
	cfa_pkg::state_t state_q, state_nx;
	logic [1:0] st_q, st_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfa_pkg::S_IDLE;
			st_q <= cfa_pkg::ST_OK;
		end else begin
			state_q <= state_nx;
			st_q <= st_nx;
		end
	end

	assign busy = (state_q != cfa_pkg::S_IDLE);

	// next state and commands
	always_comb begin
		state_nx = state_q;
		st_nx = st_q;
		cmd = '0;
		cmd.st = st_q;
		unique case (state_q)
			cfa_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					st_nx = cfa_pkg::ST_OK;
					state_nx = cfa_pkg::S_DECIDE;
				end
			end
			cfa_pkg::S_DECIDE: begin
				cmd.clr_idx = 1'b1;
				unique case (sts.func)
					cfa_pkg::FUNC_ADD: begin
						if (!sts.region_ok) state_nx = cfa_pkg::S_DONE;
						else if (sts.hfull) begin
							st_nx = cfa_pkg::ST_FULL;
							state_nx = cfa_pkg::S_DONE;
						end else begin
							cmd.clr_idx = 1'b0;
							cmd.set_idx_cnt_h = 1'b1;
							state_nx = cfa_pkg::S_HINS;
						end
					end
					cfa_pkg::FUNC_ALLOC: begin
						if (sts.sfull) begin
							st_nx = cfa_pkg::ST_FULL;
							state_nx = cfa_pkg::S_DONE;
						end else state_nx = cfa_pkg::S_HSCAN;
					end
					cfa_pkg::FUNC_FREE: state_nx = cfa_pkg::S_SSCAN;
					default: begin
						if (sts.hcnt_gt1) begin
							cmd.step_idx = 1'b1;
							cmd.clr_idx = 1'b0;
							state_nx = cfa_pkg::S_MERGE;
						end else state_nx = cfa_pkg::S_DONE;
					end
				endcase
			end
			cfa_pkg::S_HSCAN: begin
				if (sts.idx_at_h || (sts.hfound && sts.first_mode)) begin
					if (!sts.hfound) begin
						st_nx = cfa_pkg::ST_NO_FIT;
						state_nx = cfa_pkg::S_DONE;
					end else if (sts.exact) begin
						cmd.set_idx_pick = 1'b1;
						state_nx = cfa_pkg::S_HDROP;
					end else begin
						cmd.hstart_upd = 1'b1;
						cmd.set_idx_cnt_s = 1'b1;
						state_nx = cfa_pkg::S_SINS;
					end
				end else begin
					cmd.hscan = 1'b1;
					cmd.step_idx = 1'b1;
				end
			end
			cfa_pkg::S_HDROP: begin
				if (sts.drop_last_h) begin
					cmd.hdrop_fin = 1'b1;
					cmd.set_idx_cnt_s = 1'b1;
					state_nx = cfa_pkg::S_SINS;
				end else begin
					cmd.hdrop_shift = 1'b1;
					cmd.step_idx = 1'b1;
				end
			end
			cfa_pkg::S_SINS: begin
				if (sts.sshift_cond) begin
					cmd.sins_shift = 1'b1;
					cmd.dec_idx = 1'b1;
				end else begin
					cmd.sins_put = 1'b1;
					state_nx = cfa_pkg::S_DONE;
				end
			end
			cfa_pkg::S_SSCAN: begin
				if (sts.sfound) begin
					// capture the segment either way, it is reported on a full hole table
					cmd.set_idx_at = 1'b1;
					if (sts.seg_nonempty && sts.hfull) begin
						st_nx = cfa_pkg::ST_FULL;
						state_nx = cfa_pkg::S_DONE;
					end else begin
						state_nx = cfa_pkg::S_SDROP;
					end
				end else if (sts.idx_at_s) begin
					st_nx = cfa_pkg::ST_NO_ID;
					state_nx = cfa_pkg::S_DONE;
				end else cmd.step_idx = 1'b1;
			end
			cfa_pkg::S_SDROP: begin
				if (sts.drop_last_s) begin
					cmd.sdrop_fin = 1'b1;
					if (sts.free_nonempty) begin
						cmd.set_idx_cnt_h = 1'b1;
						state_nx = cfa_pkg::S_HINS;
					end else state_nx = cfa_pkg::S_DONE;
				end else begin
					cmd.sdrop_shift = 1'b1;
					cmd.step_idx = 1'b1;
				end
			end
			cfa_pkg::S_HINS: begin
				if (sts.hshift_cond) begin
					cmd.hins_shift = 1'b1;
					cmd.dec_idx = 1'b1;
				end else begin
					cmd.hins_put = 1'b1;
					state_nx = cfa_pkg::S_DONE;
				end
			end
			cfa_pkg::S_MERGE: begin
				if (sts.idx_at_h) begin
					cmd.merge_fin = 1'b1;
					state_nx = cfa_pkg::S_DONE;
				end else begin
					cmd.merge_step = 1'b1;
					cmd.step_idx = 1'b1;
				end
			end
			cfa_pkg::S_DONE: begin
				cmd.done = 1'b1;
				state_nx = cfa_pkg::S_IDLE;
			end
			default: state_nx = cfa_pkg::S_IDLE;
		endcase
	end
endmodule

>>> hdl/cfa_dp.sv
// datapath: hole and segment tables, scan registers and result register
`timescale 1ns / 1ps
module cfa_dp #(
	parameter int HOLE_SLOTS = cfa_pkg::HOLE_SLOTS_DEF,
	parameter int SEG_SLOTS = cfa_pkg::SEG_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfa_pkg::req_t req,
	input logic [1:0] fit_mode,
	input cfa_pkg::cmd_t cmd,
	output cfa_pkg::sts_t sts,
	output logic done,
	output cfa_pkg::rsp_t rsp
);
	localparam int AW = cfa_pkg::ADDR_BITS;
	localparam int HCW = $clog2(HOLE_SLOTS + 1);
	localparam int SCW = $clog2(SEG_SLOTS + 1);
	localparam int HIW = $clog2(HOLE_SLOTS);
	localparam int SIW = $clog2(SEG_SLOTS);
	localparam int IW = (HCW > SCW) ? HCW : SCW;

	logic [AW-1:0] hs_q [HOLE_SLOTS];
	logic [AW-1:0] he_q [HOLE_SLOTS];
	logic [cfa_pkg::ID_BITS-1:0] so_q [SEG_SLOTS];
	logic [AW-1:0] sb_q [SEG_SLOTS];
	logic [AW-1:0] sl_q [SEG_SLOTS];
	logic [HCW-1:0] hcnt_q;
	logic [SCW-1:0] scnt_q;
	cfa_pkg::req_t req_q;
	logic [IW-1:0] idx_q, w_q;
	logic found_q;
	logic [HIW-1:0] pick_q;
	logic [AW-1:0] best_q;
	logic [AW-1:0] a_q, b_q;
	logic done_q;
	cfa_pkg::rsp_t rsp_q;

	logic [HIW-1:0] hi, hi_m1, wi;
	logic [SIW-1:0] si, si_m1;
	logic [AW-1:0] hsz, alloc_end;
	logic better;

	assign hi = idx_q[HIW-1:0];
	assign hi_m1 = hi - 1'b1;
	assign si = idx_q[SIW-1:0];
	assign si_m1 = si - 1'b1;
	assign wi = w_q[HIW-1:0];
	assign hsz = he_q[hi] - hs_q[hi];
	assign alloc_end = hs_q[pick_q] + req_q.req_size;
	assign better = (fit_mode == cfa_pkg::FIT_BEST && hsz < best_q) ||
		(fit_mode == cfa_pkg::FIT_WORST && hsz > best_q);

	// status toward controller
	always_comb begin
		sts.func = req_q.func;
		sts.hfull = (hcnt_q >= HCW'(HOLE_SLOTS));
		sts.sfull = (scnt_q >= SCW'(SEG_SLOTS));
		sts.region_ok = (req_q.region_end > req_q.region_start);
		sts.idx_at_h = (idx_q >= IW'(hcnt_q));
		sts.idx_at_s = (idx_q >= IW'(scnt_q));
		sts.seg_nonempty = (sl_q[si] > sb_q[si]);
		sts.hshift_cond = (idx_q != '0) && (hs_q[hi_m1] > a_q);
		sts.sshift_cond = (idx_q != '0) && (sb_q[si_m1] > a_q);
		sts.hfound = found_q;
		sts.first_mode = (fit_mode != cfa_pkg::FIT_BEST) &&
			(fit_mode != cfa_pkg::FIT_WORST);
		sts.sfound = !sts.idx_at_s && (so_q[si] == req_q.proc_id);
		sts.exact = (best_q == req_q.req_size);
		sts.free_nonempty = (b_q > a_q);
		sts.hcnt_gt1 = (hcnt_q > HCW'(1));
		sts.drop_last_h = (IW'(idx_q + 1'b1) >= IW'(hcnt_q));
		sts.drop_last_s = (IW'(idx_q + 1'b1) >= IW'(scnt_q));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			scnt_q <= '0;
			done_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.load) idx_q <= '0;
			if (cmd.clr_idx) idx_q <= '0;
			if (cmd.step_idx) idx_q <= idx_q + 1'b1;
			if (cmd.dec_idx) idx_q <= idx_q - 1'b1;
			if (cmd.set_idx_cnt_h) idx_q <= IW'(hcnt_q);
			if (cmd.set_idx_cnt_s) idx_q <= IW'(scnt_q);
			if (cmd.set_idx_pick) idx_q <= IW'(pick_q);
			if (cmd.set_idx_at) idx_q <= idx_q;
			if (cmd.load) found_q <= 1'b0;
			if (cmd.hscan && hsz >= req_q.req_size && (!found_q || better))
				found_q <= 1'b1;
			if (cmd.hins_put) hcnt_q <= hcnt_q + 1'b1;
			if (cmd.hdrop_fin) hcnt_q <= hcnt_q - 1'b1;
			if (cmd.merge_fin) hcnt_q <= HCW'(w_q + 1'b1);
			if (cmd.sins_put) scnt_q <= scnt_q + 1'b1;
			if (cmd.sdrop_fin) scnt_q <= scnt_q - 1'b1;
		end
	end

	// payload registers and tables
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			a_q <= '0;
			b_q <= '0;
			w_q <= '0;
			if (req.func == cfa_pkg::FUNC_ADD) begin
				a_q <= req.region_start;
				b_q <= req.region_end;
			end
		end
		if (cmd.hscan && hsz >= req_q.req_size && (!found_q || better)) begin
			pick_q <= hi;
			best_q <= hsz;
		end
		if (cmd.hstart_upd || cmd.set_idx_pick) begin
			a_q <= hs_q[pick_q];
			b_q <= alloc_end;
		end
		if (cmd.hstart_upd) hs_q[pick_q] <= alloc_end;
		if (cmd.set_idx_at) begin
			a_q <= sb_q[si];
			b_q <= sl_q[si];
		end
		if (cmd.hins_shift) begin
			hs_q[hi] <= hs_q[hi_m1];
			he_q[hi] <= he_q[hi_m1];
		end
		if (cmd.hins_put) begin
			hs_q[hi] <= a_q;
			he_q[hi] <= b_q;
		end
		if (cmd.hdrop_shift) begin
			hs_q[hi] <= hs_q[HIW'(hi + 1'b1)];
			he_q[hi] <= he_q[HIW'(hi + 1'b1)];
		end
		if (cmd.sins_shift) begin
			so_q[si] <= so_q[si_m1];
			sb_q[si] <= sb_q[si_m1];
			sl_q[si] <= sl_q[si_m1];
		end
		if (cmd.sins_put) begin
			so_q[si] <= req_q.proc_id;
			sb_q[si] <= a_q;
			sl_q[si] <= b_q;
		end
		if (cmd.sdrop_shift) begin
			so_q[si] <= so_q[SIW'(si + 1'b1)];
			sb_q[si] <= sb_q[SIW'(si + 1'b1)];
			sl_q[si] <= sl_q[SIW'(si + 1'b1)];
		end
		// coalesce pass, w trails the read index
		if (cmd.merge_step) begin
			if (hs_q[hi] == he_q[wi]) begin
				he_q[wi] <= he_q[hi];
			end else begin
				w_q <= w_q + 1'b1;
				hs_q[HIW'(wi + 1'b1)] <= hs_q[hi];
				he_q[HIW'(wi + 1'b1)] <= he_q[hi];
			end
		end
		if (cmd.done) begin
			rsp_q.status <= cmd.st;
			rsp_q.seg_start <= (cmd.st == cfa_pkg::ST_OK || cmd.st == cfa_pkg::ST_FULL) ?
				a_q : '0;
			rsp_q.seg_end <= (cmd.st == cfa_pkg::ST_OK || cmd.st == cfa_pkg::ST_FULL) ?
				b_q : '0;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;
endmodule

>>> hdl/contiguous_fit_allocator_unit.sv
// top level of the contiguous fit allocator
// an alloc scans the hole table, then drops or trims the chosen hole and inserts a segment
// throughput: one item at a time, busy is high from accept until the result strobe
// the result strobe is high for one cycle and cannot be stalled
// reset clears counts, mode and control; table contents stay undefined
`timescale 1ns / 1ps
module contiguous_fit_allocator_unit #(
	parameter int HOLE_SLOTS = cfa_pkg::HOLE_SLOTS_DEF,
	parameter int SEG_SLOTS = cfa_pkg::SEG_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cfa_pkg::req_t req,
	input logic cfg_we,
	input logic [1:0] cfg_wdata,
	output logic done,
	output cfa_pkg::rsp_t rsp
);
	cfa_pkg::cmd_t cmd;
	cfa_pkg::sts_t sts;
	logic [1:0] fit_mode_q;

	// placement policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fit_mode_q <= cfa_pkg::FIT_FIRST;
		else if (cfg_we) fit_mode_q <= cfg_wdata;
	end

	cfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	cfa_dp #(.HOLE_SLOTS(HOLE_SLOTS), .SEG_SLOTS(SEG_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .fit_mode(fit_mode_q), .cmd(cmd),
		.sts(sts), .done(done), .rsp(rsp)
	);
endmodule

>>> hdl/cfa_checker.sv
// port-level checker for the allocator and its bind
`timescale 1ns / 1ps
module cfa_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input cfa_pkg::rsp_t rsp
);
	// accept makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");
	// strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	// strobe only after busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	// no-fit and no-id results carry zero addresses
	a_zero_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == cfa_pkg::ST_NO_FIT || rsp.status == cfa_pkg::ST_NO_ID)
		|-> rsp.seg_start == '0 && rsp.seg_end == '0) else $error("failed item with address");
endmodule

bind contiguous_fit_allocator_unit cfa_checker u_cfa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
